[hdl/fcpsg_pkg.sv]
// Shared constants, register offsets and helper functions of the sound unit.
package fcpsg_pkg;

	// Output sample rate in Hz
	localparam int SAMPLE_RATE = 16000;
	// Envelope tick length in samples per period unit
	localparam int ENV_UNIT = SAMPLE_RATE / 64;
	localparam int ECNT_W = $clog2(7 * ENV_UNIT + 1);
	// DC blocker feedback coefficient, Q15
	localparam logic signed [15:0] DC_COEF = 16'sd32604;

	// Step divider sizes
	localparam int NUM_W = 38;
	localparam int DEN_W = $clog2(2048 * SAMPLE_RATE + 1);
	localparam int DCNT_W = $clog2(NUM_W);

	// Reciprocal of the sample rate scaled by 2^48, rounded up; the noise step is
	// hz * 65536 / SAMPLE_RATE, taken as (hz * NZ_RECIP) >> 32
	localparam longint unsigned NZ_RECIP =
		((64'd1 << 48) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);

	// Item kinds
	localparam logic [1:0] OP_WR = 2'd0;
	localparam logic [1:0] OP_RD = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Register offsets from the bus base
	localparam logic [5:0] RG_DUTY1 = 6'h01;
	localparam logic [5:0] RG_ENV1 = 6'h02;
	localparam logic [5:0] RG_LO1 = 6'h03;
	localparam logic [5:0] RG_HI1 = 6'h04;
	localparam logic [5:0] RG_DUTY2 = 6'h06;
	localparam logic [5:0] RG_ENV2 = 6'h07;
	localparam logic [5:0] RG_LO2 = 6'h08;
	localparam logic [5:0] RG_HI2 = 6'h09;
	localparam logic [5:0] RG_WON = 6'h0A;
	localparam logic [5:0] RG_WLVL = 6'h0C;
	localparam logic [5:0] RG_WLO = 6'h0D;
	localparam logic [5:0] RG_WHI = 6'h0E;
	localparam logic [5:0] RG_NENV = 6'h11;
	localparam logic [5:0] RG_NPOLY = 6'h12;
	localparam logic [5:0] RG_NCTL = 6'h13;
	localparam logic [5:0] RG_VOL = 6'h14;
	localparam logic [5:0] RG_PAN = 6'h15;
	localparam logic [5:0] RG_PWR = 6'h16;

	// Slots of the registers fetched at the start of a tick
	localparam logic [2:0] TR_DUTY1 = 3'd0;
	localparam logic [2:0] TR_ENV1 = 3'd1;
	localparam logic [2:0] TR_DUTY2 = 3'd2;
	localparam logic [2:0] TR_ENV2 = 3'd3;
	localparam logic [2:0] TR_WON = 3'd4;
	localparam logic [2:0] TR_WLVL = 3'd5;
	localparam logic [2:0] TR_NENV = 3'd6;
	localparam logic [2:0] TR_NPOLY = 3'd7;

	typedef struct packed {
		logic [ECNT_W-1:0] cnt;
		logic [3:0] vol;
	} env_t;

	// Bits that always read as one
	function automatic logic [7:0] read_mask(input logic [5:0] idx);
		logic [7:0] m;
		case (idx)
			6'h00: m = 8'h80;
			6'h01: m = 8'h3F;
			6'h02: m = 8'h00;
			6'h04: m = 8'hBF;
			6'h06: m = 8'h3F;
			6'h07: m = 8'h00;
			6'h09: m = 8'hBF;
			6'h0A: m = 8'h7F;
			6'h0C: m = 8'h9F;
			6'h0E: m = 8'hBF;
			6'h11: m = 8'h00;
			6'h12: m = 8'h00;
			6'h13: m = 8'hBF;
			6'h14: m = 8'h00;
			6'h15: m = 8'h00;
			6'h16: m = 8'h70;
			default: m = (idx < 6'h20) ? 8'hFF : 8'h00;
		endcase
		return m;
	endfunction

	// Register that pairs with a written one for a step or gain update
	function automatic logic [5:0] partner(input logic [5:0] idx);
		logic [5:0] p;
		case (idx)
			RG_LO1: p = RG_HI1;
			RG_HI1: p = RG_LO1;
			RG_LO2: p = RG_HI2;
			RG_HI2: p = RG_LO2;
			RG_WLO: p = RG_WHI;
			RG_WHI: p = RG_WLO;
			RG_VOL: p = RG_PAN;
			RG_PAN: p = RG_VOL;
			default: p = idx;
		endcase
		return p;
	endfunction

	// Register consulted when a trigger bit is written
	function automatic logic [5:0] trig_src(input logic [5:0] idx);
		logic [5:0] p;
		case (idx)
			RG_HI1: p = RG_ENV1;
			RG_HI2: p = RG_ENV2;
			RG_WHI: p = RG_WON;
			RG_NCTL: p = RG_NENV;
			default: p = idx;
		endcase
		return p;
	endfunction

	// Fetch order of a tick
	function automatic logic [5:0] tick_addr(input logic [2:0] slot);
		logic [5:0] a;
		case (slot)
			TR_DUTY1: a = RG_DUTY1;
			TR_ENV1: a = RG_ENV1;
			TR_DUTY2: a = RG_DUTY2;
			TR_ENV2: a = RG_ENV2;
			TR_WON: a = RG_WON;
			TR_WLVL: a = RG_WLVL;
			TR_NENV: a = RG_NENV;
			default: a = RG_NPOLY;
		endcase
		return a;
	endfunction

	function automatic logic [15:0] duty_limit(input logic [1:0] d);
		logic [15:0] l;
		case (d)
			2'd0: l = 16'd8192;
			2'd1: l = 16'd16384;
			2'd2: l = 16'd32768;
			default: l = 16'd49152;
		endcase
		return l;
	endfunction

	// Noise base clock in Hz per divider code
	function automatic logic [16:0] noise_hz(input logic [2:0] c);
		logic [16:0] h;
		case (c)
			3'd0: h = 17'(524288 / 8);
			3'd1: h = 17'(524288 / 16);
			3'd2: h = 17'(524288 / 32);
			3'd3: h = 17'(524288 / 48);
			3'd4: h = 17'(524288 / 64);
			3'd5: h = 17'(524288 / 80);
			3'd6: h = 17'(524288 / 96);
			default: h = 17'(524288 / 112);
		endcase
		return h;
	endfunction

	// One envelope tick
	function automatic env_t env_step(input logic [7:0] r, input env_t e);
		env_t n;
		logic [ECNT_W:0] nc;
		logic [ECNT_W:0] thr;
		n = e;
		nc = (ECNT_W + 1)'(e.cnt) + 1'b1;
		thr = (ECNT_W + 1)'(r[2:0]) * (ECNT_W + 1)'(ENV_UNIT);
		if (r[2:0] != 3'd0) begin
			if (nc < thr) begin
				n.cnt = nc[ECNT_W-1:0];
			end else begin
				n.cnt = '0;
				if (r[3]) begin
					if (e.vol != 4'hF) n.vol = e.vol + 4'd1;
				end else if (e.vol != 4'h0) begin
					n.vol = e.vol - 4'd1;
				end
			end
		end
		return n;
	endfunction

	// One noise shift register clock
	function automatic logic [14:0] lfsr_step(input logic [14:0] s, input logic narrow);
		logic b;
		logic [14:0] n;
		b = s[0] ^ s[1];
		n = {b, s[14:1]};
		if (narrow) n[6] = b;
		return n;
	endfunction

endpackage

[hdl/four_channel_psg_with_dc_block_top.sv]
// Four-channel sound unit with mono mix and DC blocker, register file in RAM.
//
// Each beat on the slave side is a bus write, a bus read or a sample tick; each
// gives exactly one beat on the master side. The 48 registers sit in a
// single-port RAM with a registered read, so the block works on one item at
// a time. A tick fetches its control registers, then clocks the noise register
// once per noise phase wrap (up to five times); while powered off it goes
// straight to the result. A write to the power register or outside the register
// range skips the partner and trigger reads, and a write to a pulse or wave
// frequency register runs the bit-serial step divider before the output register.
module four_channel_psg_with_dc_block_top
	import fcpsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // addr[15:0], wdata[23:16]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // read_data[7:0], sample[23:8]
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD0 = 4'd1;
	localparam logic [3:0] S_RD1 = 4'd2;
	localparam logic [3:0] S_WR0 = 4'd3;
	localparam logic [3:0] S_WR1 = 4'd4;
	localparam logic [3:0] S_WR2 = 4'd5;
	localparam logic [3:0] S_WR3 = 4'd6;
	localparam logic [3:0] S_DIV = 4'd7;
	localparam logic [3:0] S_TFET = 4'd8;
	localparam logic [3:0] S_TCH = 4'd9;
	localparam logic [3:0] S_TWV = 4'd10;
	localparam logic [3:0] S_TNZ = 4'd11;
	localparam logic [3:0] S_TMIX = 4'd12;
	localparam logic [3:0] S_TDC = 4'd13;
	localparam logic [3:0] S_DONE = 4'd14;

	localparam logic [1:0] DT_P0 = 2'd0;
	localparam logic [1:0] DT_P1 = 2'd1;
	localparam logic [1:0] DT_WV = 2'd2;

	// Register file RAM and its valid bits
	logic [7:0] mem [48];
	logic [47:0] vld_q;
	logic [7:0] rd_q;
	logic rdv_q;
	logic [5:0] mem_addr;
	logic mem_we;
	logic [7:0] mem_wd;
	logic [7:0] rdata;

	logic [3:0] st_q;
	logic [5:0] idx_q;
	logic inrng_q;
	logic [7:0] wd_q;
	logic [7:0] part_q;
	logic [3:0] cnt_q;
	logic [7:0] tr_q [8];

	// Channel state
	logic master_on_q;
	logic [3:0] en_q;
	logic [15:0] pph_q [2];
	logic [19:0] pstep_q [2];
	env_t env_q [3];
	logic [20:0] wph_q;
	logic [23:0] wstep_q;
	logic [15:0] nph_q;
	logic [18:0] nstep_q;
	logic [14:0] nsr_q;
	logic [4:0] gain_q [4];
	logic signed [15:0] dcin_q;
	logic signed [15:0] dcout_q;

	// Tick working registers
	logic signed [7:0] cho_q [4];
	logic wpos0_q;
	logic nact_q;
	logic [19:0] nacc_q;
	logic signed [17:0] mix_q;
	logic signed [31:0] prod_q;

	// Divider
	logic [NUM_W-1:0] dnum_q;
	logic [DEN_W-1:0] dden_q;
	logic [DEN_W-1:0] drem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [1:0] dtgt_q;

	// Result
	logic [7:0] res_rd_q;
	logic [15:0] res_smp_q;
	logic m_tvalid_q;
	logic [23:0] m_tdata_q;

	// Combinational helpers
	logic [7:0] penv [2];
	logic [7:0] pduty [2];
	logic pact [2];
	logic [15:0] pph_n [2];
	env_t penv_n [2];
	logic signed [7:0] pout [2];
	logic [6:0] pmag [2];
	logic wact;
	logic [20:0] wph_n;
	logic [3:0] wnib;
	logic signed [5:0] wval;
	env_t nenv_n;
	logic [6:0] nmag;
	logic signed [15:0] mix_sum;
	logic signed [16:0] fb;
	logic signed [19:0] ysum;
	logic signed [15:0] ysat;
	logic [DEN_W:0] remx;
	logic dge;
	logic [NUM_W-1:0] dq_n;
	logic [10:0] wfreq;
	logic [11:0] wdist;
	logic [16:0] nhz;
	logic [52:0] nzprod;
	logic [7:0] gvol;
	logic [7:0] gpan;
	logic [3:0] grg;
	logic [3:0] glg;
	logic trig;
	logic [2:0] tslot;

	assign rdata = rdv_q ? rd_q : 8'h00;
	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign tslot = 3'(cnt_q - 4'd1);

	// Pick the RAM port address for this cycle
	always_comb begin
		mem_addr = 6'h00;
		mem_we = 1'b0;
		mem_wd = wd_q;
		case (st_q)
			S_WR0: begin
				mem_addr = idx_q;
				mem_we = inrng_q;
				if (idx_q == RG_PWR) mem_wd = {wd_q[7], 7'b0};
			end
			S_WR1: mem_addr = partner(idx_q);
			S_WR2: mem_addr = trig_src(idx_q);
			S_RD0: mem_addr = inrng_q ? idx_q : 6'h00;
			S_TFET: mem_addr = tick_addr(cnt_q[2:0]);
			S_TCH: mem_addr = {2'b10, wph_n[20:17]};
			default: mem_addr = 6'h00;
		endcase
	end

	// Register file RAM
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (mem_we) vld_q[mem_addr] <= 1'b1;
			rdv_q <= vld_q[mem_addr];
		end
	end

	// Channel arithmetic of a tick
	always_comb begin
		penv[0] = tr_q[TR_ENV1];
		penv[1] = tr_q[TR_ENV2];
		pduty[0] = tr_q[TR_DUTY1];
		pduty[1] = tr_q[TR_DUTY2];
		for (int k = 0; k < 2; k++) begin
			pact[k] = en_q[k] && (penv[k][7:3] != 5'd0);
			pph_n[k] = pph_q[k] + pstep_q[k][15:0];
			penv_n[k] = env_step(penv[k], env_q[k]);
			pmag[k] = {penv_n[k].vol, 3'b000};
			pout[k] = (pph_n[k] < duty_limit(pduty[k][7:6])) ?
				$signed({1'b0, pmag[k]}) : -$signed({1'b0, pmag[k]});
		end
		wact = en_q[2] && tr_q[TR_WON][7] && (tr_q[TR_WLVL][6:5] != 2'd0);
		wph_n = wph_q + wstep_q[20:0];
		wnib = wpos0_q ? rdata[3:0] : rdata[7:4];
		case (tr_q[TR_WLVL][6:5])
			2'd1: wval = $signed({2'b00, wnib}) - 6'sd8;
			2'd2: wval = $signed({3'b000, wnib[3:1]}) - 6'sd4;
			default: wval = $signed({4'b0000, wnib[3:2]}) - 6'sd2;
		endcase
		nenv_n = env_step(tr_q[TR_NENV], env_q[2]);
		nmag = {nenv_n.vol, 3'b000};
		mix_sum = 16'(cho_q[0]) * 16'($signed({1'b0, gain_q[0]}))
			+ 16'(cho_q[1]) * 16'($signed({1'b0, gain_q[1]}))
			+ 16'(cho_q[2]) * 16'($signed({1'b0, gain_q[2]}))
			+ 16'(cho_q[3]) * 16'($signed({1'b0, gain_q[3]}));
		fb = prod_q[31:15];
		ysum = 20'(mix_q) - 20'(dcin_q) + 20'(fb);
		if (ysum > 20'sd32767) ysat = 16'sh7FFF;
		else if (ysum < -20'sd32768) ysat = 16'sh8000;
		else ysat = ysum[15:0];
	end

	// Divider step and write-side operand selection
	always_comb begin
		remx = {drem_q, dnum_q[NUM_W-1]};
		dge = (remx >= {1'b0, dden_q});
		dq_n = {dnum_q[NUM_W-2:0], dge};
		if (idx_q == RG_LO1 || idx_q == RG_LO2 || idx_q == RG_WLO) begin
			wfreq = {part_q[2:0], wd_q};
		end else begin
			wfreq = {wd_q[2:0], part_q};
		end
		wdist = 12'h800 - {1'b0, wfreq};
		nhz = (wd_q[7:4] != 4'hF) ? (noise_hz(wd_q[2:0]) >> wd_q[7:4]) : 17'd0;
		// Noise step by reciprocal of the sample rate
		nzprod = 53'(nhz) * 53'(NZ_RECIP);
		gvol = (idx_q == RG_VOL) ? wd_q : part_q;
		gpan = (idx_q == RG_VOL) ? part_q : wd_q;
		grg = {1'b0, gvol[2:0]} + 4'd1;
		glg = {1'b0, gvol[6:4]} + 4'd1;
		trig = master_on_q && wd_q[7];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			master_on_q <= 1'b0;
			en_q <= '0;
			pph_q[0] <= '0;
			pph_q[1] <= '0;
			pstep_q[0] <= '0;
			pstep_q[1] <= '0;
			env_q[0] <= '0;
			env_q[1] <= '0;
			env_q[2] <= '0;
			wph_q <= '0;
			wstep_q <= '0;
			nph_q <= '0;
			nstep_q <= '0;
			nsr_q <= '0;
			for (int c = 0; c < 4; c++) gain_q[c] <= '0;
			dcin_q <= '0;
			dcout_q <= '0;
			m_tvalid_q <= 1'b0;
			cnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			// Drain the output register
			if (m_tready && st_q != S_DONE) m_tvalid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					res_rd_q <= 8'h00;
					res_smp_q <= 16'h0000;
					if (s_tvalid) begin
						wd_q <= s_tdata[23:16];
						idx_q <= s_tdata[5:0] - 6'h10;
						inrng_q <= (s_tdata[15:8] == 8'hFF) && (s_tdata[7:6] == 2'b00)
							&& (s_tdata[5:4] != 2'b00);
						cnt_q <= '0;
						case (s_tuser)
							OP_WR: st_q <= S_WR0;
							OP_RD: st_q <= S_RD0;
							OP_TICK: st_q <= master_on_q ? S_TFET : S_DONE;
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_RD0: st_q <= S_RD1;
				S_RD1: begin
					res_rd_q <= inrng_q ? (rdata | read_mask(idx_q)) : 8'hFF;
					st_q <= S_DONE;
				end
				// Store the byte; the power register acts at once
				S_WR0: begin
					if (!inrng_q) begin
						st_q <= S_DONE;
					end else if (idx_q == RG_PWR) begin
						master_on_q <= wd_q[7];
						if (!wd_q[7]) begin
							en_q <= '0;
							dcin_q <= '0;
							dcout_q <= '0;
						end
						st_q <= S_DONE;
					end else begin
						st_q <= S_WR1;
					end
				end
				S_WR1: st_q <= S_WR2;
				S_WR2: begin
					part_q <= rdata;
					st_q <= S_WR3;
				end
				// Gains, noise step, triggers and divider launch
				S_WR3: begin
					dcnt_q <= '0;
					drem_q <= '0;
					dden_q <= DEN_W'(wdist) * DEN_W'(SAMPLE_RATE);
					if (idx_q inside {RG_LO1, RG_HI1, RG_LO2, RG_HI2, RG_WLO, RG_WHI}) begin
						st_q <= S_DIV;
					end else begin
						st_q <= S_DONE;
					end
					case (idx_q)
						RG_VOL, RG_PAN: begin
							for (int c = 0; c < 4; c++) begin
								gain_q[c] <= (gpan[c] ? {1'b0, grg} : 5'd0)
									+ (gpan[c + 4] ? {1'b0, glg} : 5'd0);
							end
						end
						RG_LO1, RG_HI1: begin
							dnum_q <= NUM_W'(1) << 33;
							dtgt_q <= DT_P0;
						end
						RG_LO2, RG_HI2: begin
							dnum_q <= NUM_W'(1) << 33;
							dtgt_q <= DT_P1;
						end
						RG_WLO, RG_WHI: begin
							dnum_q <= NUM_W'(1) << 37;
							dtgt_q <= DT_WV;
						end
						RG_NPOLY: nstep_q <= nzprod[50:32];
						default: ;
					endcase
					if (trig) begin
						case (idx_q)
							RG_HI1: begin
								en_q[0] <= (rdata[7:3] != 5'd0);
								pph_q[0] <= '0;
								env_q[0] <= '{cnt: '0, vol: rdata[7:4]};
							end
							RG_HI2: begin
								en_q[1] <= (rdata[7:3] != 5'd0);
								pph_q[1] <= '0;
								env_q[1] <= '{cnt: '0, vol: rdata[7:4]};
							end
							RG_WHI: begin
								en_q[2] <= rdata[7];
								wph_q <= '0;
							end
							RG_NCTL: begin
								en_q[3] <= (rdata[7:3] != 5'd0);
								nph_q <= '0;
								nsr_q <= 15'h7FFF;
								env_q[2] <= '{cnt: '0, vol: rdata[7:4]};
							end
							default: ;
						endcase
					end
				end
				// Restoring division, one quotient bit per cycle
				S_DIV: begin
					drem_q <= dge ? DEN_W'(remx - {1'b0, dden_q}) : remx[DEN_W-1:0];
					dnum_q <= dq_n;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
						case (dtgt_q)
							DT_P0: pstep_q[0] <= dq_n[19:0];
							DT_P1: pstep_q[1] <= dq_n[19:0];
							default: wstep_q <= dq_n[23:0];
						endcase
						st_q <= S_DONE;
					end
				end
				// Fetch the control registers of a tick
				S_TFET: begin
					if (cnt_q != 4'd0) tr_q[tslot] <= rdata;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd8) st_q <= S_TCH;
				end
				// Advance pulses, wave phase and noise phase
				S_TCH: begin
					for (int k = 0; k < 2; k++) begin
						if (pact[k]) begin
							pph_q[k] <= pph_n[k];
							env_q[k] <= penv_n[k];
							cho_q[k] <= pout[k];
						end else begin
							cho_q[k] <= 8'sd0;
						end
					end
					if (wact) wph_q <= wph_n;
					wpos0_q <= wph_n[16];
					nact_q <= en_q[3] && (tr_q[TR_NENV][7:3] != 5'd0);
					nacc_q <= {4'b0, nph_q} + {1'b0, nstep_q};
					st_q <= S_TWV;
				end
				S_TWV: begin
					if (!wact) cho_q[2] <= 8'sd0;
					else cho_q[2] <= 8'({wval, 3'b000});
					st_q <= S_TNZ;
				end
				// Clock the noise register once per phase wrap
				S_TNZ: begin
					if (!nact_q) begin
						cho_q[3] <= 8'sd0;
						st_q <= S_TMIX;
					end else if (nacc_q[19:16] != 4'd0) begin
						nacc_q <= nacc_q - 20'h10000;
						nsr_q <= lfsr_step(nsr_q, tr_q[TR_NPOLY][3]);
					end else begin
						nph_q <= nacc_q[15:0];
						env_q[2] <= nenv_n;
						cho_q[3] <= nsr_q[0] ? -$signed({1'b0, nmag}) : $signed({1'b0, nmag});
						st_q <= S_TMIX;
					end
				end
				S_TMIX: begin
					mix_q <= 18'(mix_sum) <<< 2;
					prod_q <= dcout_q * DC_COEF;
					st_q <= S_TDC;
				end
				// DC blocker and saturation
				S_TDC: begin
					dcin_q <= mix_q[15:0];
					dcout_q <= ysat;
					res_smp_q <= ysat;
					st_q <= S_DONE;
				end
				// Hand the result to the output register
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {res_smp_q, res_rd_q};
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

[verif/four_channel_psg_with_dc_block_top_test.sv]
// Testbench of the four-channel sound unit: random bus traffic and ticks checked against a predictor.
module four_channel_psg_with_dc_block_top_test;
	import fcpsg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] BUS_BASE = 16'hFF10;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic [7:0] rd;
		logic signed [15:0] smp;
	} beat_t;

	// Sound unit predictor plus queue of expected output beats
	class psg_scoreboard;
		logic [7:0] regs [48];
		bit pwr;
		bit ch_on [4];
		int unsigned ph_pulse [2];
		int unsigned st_pulse [2];
		int unsigned vol [3];
		int unsigned ecnt [3];
		int unsigned ph_wave, st_wave, ph_noise, st_noise;
		logic [14:0] lfsr;
		int gain [4];
		int dc_in, dc_out;
		beat_t pending_q [$];
		int errors;

		function new();
			foreach (regs[i]) regs[i] = 8'h00;
			pwr = 0;
			foreach (ch_on[i]) ch_on[i] = 0;
			ph_pulse = '{0, 0};
			st_pulse = '{0, 0};
			vol = '{0, 0, 0};
			ecnt = '{0, 0, 0};
			ph_wave = 0; st_wave = 0; ph_noise = 0; st_noise = 0;
			lfsr = '0;
			gain = '{0, 0, 0, 0};
			dc_in = 0; dc_out = 0;
			errors = 0;
		endfunction

		function int unsigned freq(int lo, int hi);
			return regs[lo] | ((regs[hi] & 7) << 8);
		endfunction

		function int unsigned step_div(longint unsigned num, int lo, int hi);
			longint unsigned den;
			den = longint'(2048 - freq(lo, hi)) * SAMPLE_RATE;
			return int'(num / den);
		endfunction

		function int unsigned noise_rate();
			int unsigned div [8];
			int unsigned hz;
			div = '{8, 16, 32, 48, 64, 80, 96, 112};
			hz = 524288 / div[regs[RG_NPOLY][2:0]];
			hz = (regs[RG_NPOLY][7:4] < 15) ? (hz >> regs[RG_NPOLY][7:4]) : 0;
			return int'((longint'(hz) * 65536) / SAMPLE_RATE);
		endfunction

		function void env_advance(int r, int k);
			int unsigned per;
			per = regs[r] & 7;
			if (per == 0) return;
			ecnt[k]++;
			if (ecnt[k] < per * (SAMPLE_RATE / 64)) return;
			ecnt[k] = 0;
			if (regs[r][3]) begin
				if (vol[k] < 15) vol[k]++;
			end else if (vol[k] > 0) begin
				vol[k]--;
			end
		endfunction

		function int pulse_out(int k, int dreg, int ereg);
			int unsigned lim [4];
			int mag;
			lim = '{8192, 16384, 32768, 49152};
			if (!ch_on[k] || (regs[ereg] & 8'hF8) == 0) return 0;
			ph_pulse[k] = (ph_pulse[k] + st_pulse[k]) & 16'hFFFF;
			env_advance(ereg, k);
			mag = vol[k] * 8;
			return (ph_pulse[k] < lim[regs[dreg][7:6]]) ? mag : -mag;
		endfunction

		function int wave_out();
			int unsigned lvl, pos;
			int n;
			logic [7:0] pk;
			if (!ch_on[2] || !regs[RG_WON][7]) return 0;
			lvl = regs[RG_WLVL][6:5];
			if (lvl == 0) return 0;
			ph_wave = (ph_wave + st_wave) & 32'h1FFFFF;
			pos = (ph_wave >> 16) & 31;
			pk = regs[32 + (pos >> 1)];
			n = pos[0] ? pk[3:0] : pk[7:4];
			if (lvl == 1) n = n - 8;
			else if (lvl == 2) n = (n >> 1) - 4;
			else n = (n >> 2) - 2;
			return n * 8;
		endfunction

		function int noise_out();
			logic b;
			int mag;
			if (!ch_on[3] || (regs[RG_NENV] & 8'hF8) == 0) return 0;
			ph_noise += st_noise;
			while (ph_noise >= 65536) begin
				ph_noise -= 65536;
				b = lfsr[0] ^ lfsr[1];
				lfsr = {b, lfsr[14:1]};
				if (regs[RG_NPOLY][3]) lfsr[6] = b;
			end
			env_advance(RG_NENV, 2);
			mag = vol[2] * 8;
			return lfsr[0] ? -mag : mag;
		endfunction

		function logic signed [15:0] tick();
			int mix, fb, y;
			longint p;
			if (!pwr) return 16'sd0;
			mix = pulse_out(0, RG_DUTY1, RG_ENV1) * gain[0];
			mix += pulse_out(1, RG_DUTY2, RG_ENV2) * gain[1];
			mix += wave_out() * gain[2];
			mix += noise_out() * gain[3];
			mix *= 4;
			// floor of the Q15 feedback product
			p = longint'(dc_out) * 32604;
			fb = int'(p >>> 15);
			y = mix - dc_in + fb;
			dc_in = mix;
			if (y > 32767) y = 32767;
			else if (y < -32768) y = -32768;
			dc_out = y;
			return y[15:0];
		endfunction

		function void bus_wr(logic [15:0] a, logic [7:0] v);
			int idx, rg, lg;
			if (a < BUS_BASE || a >= BUS_BASE + 48) return;
			idx = a - BUS_BASE;
			if (idx == RG_PWR) begin
				regs[idx] = v & 8'h80;
				pwr = v[7];
				if (!pwr) begin
					foreach (ch_on[i]) ch_on[i] = 0;
					dc_in = 0;
					dc_out = 0;
				end
				return;
			end
			regs[idx] = v;
			if (idx == RG_VOL || idx == RG_PAN) begin
				rg = regs[RG_VOL][2:0] + 1;
				lg = regs[RG_VOL][6:4] + 1;
				for (int c = 0; c < 4; c++)
					gain[c] = (regs[RG_PAN][c] ? rg : 0) + (regs[RG_PAN][c + 4] ? lg : 0);
			end else if (idx == RG_LO1 || idx == RG_HI1) begin
				st_pulse[0] = step_div(64'd1 << 33, RG_LO1, RG_HI1);
			end else if (idx == RG_LO2 || idx == RG_HI2) begin
				st_pulse[1] = step_div(64'd1 << 33, RG_LO2, RG_HI2);
			end else if (idx == RG_WLO || idx == RG_WHI) begin
				st_wave = step_div(64'd1 << 37, RG_WLO, RG_WHI);
			end else if (idx == RG_NPOLY) begin
				st_noise = noise_rate();
			end
			// triggers only while powered
			if (!pwr || !v[7]) return;
			if (idx == RG_HI1 || idx == RG_HI2) begin
				int k, e;
				k = (idx == RG_HI1) ? 0 : 1;
				e = (idx == RG_HI1) ? RG_ENV1 : RG_ENV2;
				ch_on[k] = (regs[e] & 8'hF8) != 0;
				ph_pulse[k] = 0;
				vol[k] = regs[e][7:4];
				ecnt[k] = 0;
			end else if (idx == RG_WHI) begin
				ch_on[2] = regs[RG_WON][7];
				ph_wave = 0;
			end else if (idx == RG_NCTL) begin
				ch_on[3] = (regs[RG_NENV] & 8'hF8) != 0;
				ph_noise = 0;
				lfsr = 15'h7FFF;
				vol[2] = regs[RG_NENV][7:4];
				ecnt[2] = 0;
			end
		endfunction

		function logic [7:0] bus_rd(logic [15:0] a);
			logic [7:0] m [48];
			int idx;
			m = '{8'h80, 8'h3F, 8'h00, 8'hFF, 8'hBF, 8'hFF, 8'h3F, 8'h00, 8'hFF, 8'hBF,
				8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hBF,
				8'h00, 8'h00, 8'h70, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
				8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
			if (a < BUS_BASE || a >= BUS_BASE + 48) return 8'hFF;
			idx = a - BUS_BASE;
			return regs[idx] | m[idx];
		endfunction

		// Note an accepted input beat and queue its result
		function void note_input(logic [1:0] op, logic [15:0] a, logic [7:0] v);
			beat_t e;
			e = '0;
			case (op)
				OP_WR: bus_wr(a, v);
				OP_RD: e.rd = bus_rd(a);
				OP_TICK: e.smp = tick();
				default: ;
			endcase
			pending_q.push_back(e);
		endfunction

		// Compare an output beat with the oldest expectation
		function void check_result(logic [23:0] d);
			beat_t e;
			if (pending_q.size() == 0) begin
				$error("output beat %h with nothing expected", d);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (d[7:0] !== e.rd) begin
				$error("read_data: expected %h, actual %h", e.rd, d[7:0]);
				errors++;
			end
			if (d[23:8] !== e.smp) begin
				$error("sample: expected %0d, actual %0d", e.smp, $signed(d[23:8]));
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 1;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [23:0] m_tdata;
	bit hold_req = 0;
	int burst_left = 0;
	psg_scoreboard sb = new();

	four_channel_psg_with_dc_block_top u_top (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Check every output beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Receiver: alternate windows of no stall and random stall, long hold-off on request
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if ((cyc / 300) % 2 == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 9) > 3);
			end
		end
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

	// Offer one beat and hold it until accepted, then maybe open a gap
	task automatic send(logic [1:0] op, logic [15:0] a, logic [7:0] v);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {v, a};
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, a, v);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	task automatic wr(logic [5:0] r, logic [7:0] v);
		send(OP_WR, BUS_BASE + r, v);
	endtask

	// Stop offering until every expected beat is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_q.size() != 0);
	endtask

	task automatic random_item();
		logic [5:0] useful [18];
		int r;
		logic [7:0] v;
		useful = '{RG_DUTY1, RG_ENV1, RG_LO1, RG_HI1, RG_DUTY2, RG_ENV2, RG_LO2, RG_HI2,
			RG_WON, RG_WLVL, RG_WLO, RG_WHI, RG_NENV, RG_NPOLY, RG_NCTL, RG_VOL, RG_PAN,
			6'h00};
		r = $urandom_range(0, 99);
		v = 8'($urandom);
		if (r < 55) send(OP_TICK, 16'($urandom), 8'($urandom));
		else if (r < 75) wr(useful[$urandom_range(0, 17)], v);
		else if (r < 85) send(OP_RD, BUS_BASE + 16'($urandom_range(0, 47)), v);
		else if (r < 89) wr(6'h20 + 6'($urandom_range(0, 15)), v);
		else if (r < 91) wr(RG_PWR, ($urandom_range(0, 9) > 1) ? (v | 8'h80) : v);
		else if (r < 94) wr(6'($urandom_range(0, 47)), v);
		else if (r < 97) send(2'($urandom_range(0, 1)), 16'($urandom), v);
		else send(OP_NONE, 16'($urandom), v);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: power up, all channels at extreme settings
		send(OP_RD, 16'h0000, 8'h00);
		send(OP_RD, 16'hFFFF, 8'hFF);
		wr(RG_HI1, 8'h80);
		wr(RG_PWR, 8'hFF);
		wr(RG_VOL, 8'h77);
		wr(RG_PAN, 8'hFF);
		wr(RG_ENV1, 8'hF1);
		wr(RG_DUTY1, 8'hC0);
		wr(RG_LO1, 8'hFF);
		wr(RG_HI1, 8'h87);
		wr(RG_ENV2, 8'h0F);
		wr(RG_LO2, 8'h00);
		wr(RG_HI2, 8'h80);
		wr(RG_WON, 8'h80);
		wr(RG_WLVL, 8'h20);
		wr(6'h20, 8'h1F);
		wr(RG_WHI, 8'h86);
		wr(RG_NENV, 8'hF9);
		wr(RG_NPOLY, 8'h08);
		wr(RG_NCTL, 8'h80);
		repeat (4) send(OP_TICK, 16'h0000, 8'h00);
		send(OP_RD, BUS_BASE + RG_PWR, 8'h00);
		send(OP_RD, BUS_BASE + 6'h2F, 8'h00);
		send(OP_NONE, 16'hFF16, 8'h00);
		wr(RG_PWR, 8'h00);
		send(OP_TICK, 16'h0000, 8'h00);
		wr(RG_PWR, 8'h80);
		drain();

		// random traffic, with one long receiver hold-off and one full drain
		for (int i = 0; i < 1750; i++) begin
			if (i == 500) hold_req = 1;
			if (i == 1100) drain();
			random_item();
		end

		drain();
		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[files.f]
hdl/fcpsg_pkg.sv
hdl/four_channel_psg_with_dc_block_top.sv
verif/four_channel_psg_with_dc_block_top_test.sv
